// ===== rtl/core/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the byte pair substitution core.
// ----------------------------------------------------------------------------
`default_nettype none
package bps_pkg;

  localparam int unsigned PAIR_DEPTH = 65536;
  localparam int unsigned BYTE_DEPTH = 256;
  localparam int unsigned PAIR_AW    = 16;
  localparam int unsigned BYTE_AW    = 8;

  localparam logic OP_COUNT   = 1'b0;
  localparam logic OP_REPLACE = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic clr_step;    // write zero at clear address, advance
    logic clr_init;    // zero clear/scan address
    logic take_in;     // latch accepted item
    logic cnt_rd;      // issue histogram reads
    logic cnt_wr;      // write bumped counts back
    logic scan_init;   // start scan
    logic scan_step;   // step the scan
    logic scan_done;   // commit best/rare
    logic rep_do;      // perform replace step
    logic emit;        // emit queued result
  } bps_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clr_last;    // clear address at final entry
    logic scan_last;   // scan issued final read
    logic emit_empty;  // no queued results left
    logic item_op;
    logic item_last;
  } bps_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/byte_pair_substitution_core.sv =====
// ----------------------------------------------------------------------------
// byte_pair_substitution_core
// One round of byte pair substitution: count pass, scan, replace pass.
// ----------------------------------------------------------------------------
// channel  | ports                                          | handshake
// input    | in_op, in_data_byte, in_last                   | start & !busy
// result   | out_byte, out_is_header, out_last,             | out_valid, one cycle
//          | out_saved_count                                |
//
// Count byte: histogram RAM read then write.
// The last count byte is followed by a scan of the pair RAM,
// one entry a cycle, then the three header items.
// Replace byte: replace step, then its results are emitted.
// After reset a clearing pass zeroes both histograms;
// busy stays high meanwhile. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module byte_pair_substitution_core
  import bps_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_is_header,
  output logic             out_last,
  output logic [31:0]      out_saved_count
);
  bps_cmd_t cmd;
  bps_sts_t sts;

  bps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts));

  bps_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_data_byte(in_data_byte), .in_last(in_last),
    .out_valid(out_valid), .out_byte(out_byte), .out_is_header(out_is_header),
    .out_last(out_last), .out_saved_count(out_saved_count));
endmodule
`default_nettype wire

// ===== rtl/core/bps_ram.sv =====
// ----------------------------------------------------------------------------
// bps_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/bps_datapath.sv =====
// ----------------------------------------------------------------------------
// bps_datapath
// Histograms, scan compare, pair matcher and result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module bps_datapath
  import bps_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bps_cmd_t   cmd,
  output bps_sts_t        sts,
  input  wire logic       in_op,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_is_header,
  output logic            out_last,
  output logic [31:0]     out_saved_count
);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic       op_r, last_r;
  logic [7:0] byte_r;
  logic       have_prev_r;
  logic [7:0] prev_byte_r;
  logic [15:0] best_pair_r;
  logic [7:0]  rare_byte_r;
  logic [31:0] total_r;

  // clear / scan address
  logic [PAIR_AW:0] addr_r;

  // ram ports
  logic                   p_we, b_we;
  logic [PAIR_AW-1:0]     p_waddr, p_raddr;
  logic [BYTE_AW-1:0]     b_waddr, b_raddr;
  logic [COUNT_WIDTH-1:0] p_wdata, b_wdata, p_rdata, b_rdata;

  bps_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PAIR_DEPTH)) u_pair (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));
  bps_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BYTE_DEPTH)) u_byte (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata));

  logic [PAIR_AW-1:0] pidx;
  assign pidx = {prev_byte_r, byte_r};

  always_comb begin
    p_we    = 1'b0;
    b_we    = 1'b0;
    p_waddr = pidx;
    b_waddr = byte_r;
    p_wdata = (p_rdata == CMAX) ? p_rdata : p_rdata + 1'b1;
    b_wdata = (b_rdata == CMAX) ? b_rdata : b_rdata + 1'b1;
    p_raddr = pidx;
    b_raddr = byte_r;
    if (cmd.clr_step) begin
      p_we    = 1'b1;
      b_we    = (addr_r[PAIR_AW-1:BYTE_AW] == '0);
      p_waddr = addr_r[PAIR_AW-1:0];
      b_waddr = addr_r[BYTE_AW-1:0];
      p_wdata = '0;
      b_wdata = '0;
    end else if (cmd.cnt_wr) begin
      p_we = have_prev_r;
      b_we = 1'b1;
    end else if (cmd.scan_init) begin
      p_raddr = '0;
      b_raddr = '0;
    end else if (cmd.scan_step) begin
      p_raddr = addr_r[PAIR_AW-1:0];
      b_raddr = addr_r[BYTE_AW-1:0];
    end
  end

  // scan: read address issued, data returned in the next cycle; track index of data
  logic                   sv_r;   // data valid for compare
  logic [PAIR_AW-1:0]     sidx_r;
  logic [COUNT_WIDTH-1:0] bv_r, rv_r;
  logic [PAIR_AW-1:0]     bi_r;
  logic [BYTE_AW-1:0]     ri_r;
  logic                   first_r;

  // result queue, up to three entries
  logic [7:0] q_byte_r [3];
  logic [2:0] q_hdr_r, q_last_r;
  logic [1:0] q_cnt_r, q_rd_r;

  logic match;
  assign match = (prev_byte_r == best_pair_r[15:8]) && (byte_r == best_pair_r[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_byte_r <= '0;
      best_pair_r <= '0;
      rare_byte_r <= '0;
      total_r     <= '0;
      addr_r      <= '0;
      sv_r        <= 1'b0;
      q_cnt_r     <= '0;
      q_rd_r      <= '0;
      first_r     <= 1'b0;
    end else begin
      if (cmd.take_in) begin
        op_r   <= in_op;
        byte_r <= in_data_byte;
        last_r <= in_last;
      end
      if (cmd.clr_init) addr_r <= '0;
      if (cmd.clr_step) addr_r <= addr_r + 1'b1;
      if (cmd.cnt_wr) begin
        prev_byte_r <= byte_r;
        have_prev_r <= !last_r;
      end
      if (cmd.scan_init) begin
        addr_r  <= 17'd1;
        sv_r    <= 1'b1;
        sidx_r  <= '0;
        first_r <= 1'b1;
      end
      if (cmd.scan_step) begin
        addr_r <= addr_r + 1'b1;
        sv_r   <= (addr_r <= 17'(PAIR_DEPTH - 1));
        sidx_r <= addr_r[PAIR_AW-1:0];
        first_r <= 1'b0;
        if (sv_r) begin
          if (first_r || p_rdata > bv_r) begin
            bv_r <= p_rdata;
            bi_r <= sidx_r;
          end
          if (sidx_r[PAIR_AW-1:BYTE_AW] == '0 && (first_r || b_rdata < rv_r)) begin
            rv_r <= b_rdata;
            ri_r <= sidx_r[BYTE_AW-1:0];
          end
        end
      end
      if (cmd.scan_done) begin
        best_pair_r <= bi_r;
        rare_byte_r <= ri_r;
        q_byte_r[0] <= bi_r[15:8];
        q_byte_r[1] <= bi_r[7:0];
        q_byte_r[2] <= ri_r;
        q_hdr_r     <= 3'b111;
        q_last_r    <= 3'b100;
        q_cnt_r     <= 2'd3;
        q_rd_r      <= '0;
      end
      if (cmd.rep_do) begin : rep
        logic [1:0] n;
        logic       hp;
        n  = '0;
        hp = have_prev_r;
        q_hdr_r  <= '0;
        q_last_r <= '0;
        q_rd_r   <= '0;
        if (!have_prev_r) begin
          prev_byte_r <= byte_r;
          hp = 1'b1;
        end else if (match) begin
          if (total_r != 32'hFFFF_FFFF) total_r <= total_r + 1'b1;
          hp = 1'b0;
          q_byte_r[0] <= rare_byte_r;
          n = 2'd1;
        end else begin
          q_byte_r[0] <= prev_byte_r;
          prev_byte_r <= byte_r;
          n = 2'd1;
        end
        if (last_r) begin
          if (hp) begin
            q_byte_r[n] <= (have_prev_r ? byte_r : byte_r);
            n = n + 1'b1;
            hp = 1'b0;
          end
          if (n == 2'd1) q_last_r <= 3'b001;
          if (n == 2'd2) q_last_r <= 3'b010;
        end
        have_prev_r <= hp;
        q_cnt_r     <= n;
      end
      if (cmd.emit) begin
        q_rd_r  <= q_rd_r + 1'b1;
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

  assign sts.clr_last   = (addr_r[PAIR_AW-1:0] == '1);
  assign sts.scan_last  = !sv_r;
  assign sts.emit_empty = (q_cnt_r == '0);
  assign sts.item_op    = op_r;
  assign sts.item_last  = last_r;

  assign out_valid       = cmd.emit;
  assign out_byte        = q_byte_r[q_rd_r];
  assign out_is_header   = q_hdr_r[q_rd_r];
  assign out_last        = q_last_r[q_rd_r];
  assign out_saved_count = total_r;
endmodule
`default_nettype wire

// ===== rtl/core/bps_ctrl.sv =====
// ----------------------------------------------------------------------------
// bps_ctrl
// Sequencer for clearing, counting, scanning, replacing and emitting.
// ----------------------------------------------------------------------------
`default_nettype none
module bps_ctrl
  import bps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output bps_cmd_t      cmd,
  input  wire bps_sts_t sts
);
  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DISP  = 8'b0000_0100,
    S_CRD   = 8'b0000_1000,
    S_CWR   = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_SDONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   scan_go_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.item_op == OP_COUNT) begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = S_CRD;
        end else begin
          cmd.rep_do = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_CRD: state_nxt = S_CWR;
      S_CWR: begin
        cmd.cnt_wr = 1'b1;
        if (sts.item_last) state_nxt = S_SCAN;
        else state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scan_go_r) cmd.scan_init = 1'b1;
        else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = S_SDONE;
        end
      end
      S_SDONE: begin
        cmd.scan_done = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.emit_empty) state_nxt = S_IDLE;
        else cmd.emit = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // scan_init goes out on the first scan cycle, after the last count write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      scan_go_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scan_go_r <= cmd.cnt_wr && sts.item_last;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bps_checker.sv =====
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks on the byte pair substitution core.
// ----------------------------------------------------------------------------
`default_nettype none
module bps_port_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_is_header,
  input wire logic        out_last,
  input wire logic [31:0] out_saved_count
);
  // results only appear while an item is being worked on
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy");

  // accepted item makes the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept without busy");

  // running count never decreases
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_saved_count >= $past(out_saved_count))
    else $error("saved count dropped");

  // header items don't bump the count
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_header) |=> $stable(out_saved_count))
    else $error("count moved on header");

  // the final result of an item is not followed directly by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after last");
endmodule

bind byte_pair_substitution_core bps_port_checks u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_is_header(out_is_header), .out_last(out_last),
  .out_saved_count(out_saved_count));
`default_nettype wire
